>>> rtl/ernn_pkg.sv
// ----------------------------------------------------------------------------
// ernn_pkg
// Shared types and codes for the Elman RNN inference core: channel words,
// queue entries, weight table codes and the multiply-accumulate term tags.
// ----------------------------------------------------------------------------
package ernn_pkg;

    localparam int FRAC_BITS = 8;
    localparam int SEQ_LEN_W = 7;
    localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 7'd10;

    // weight table codes
    localparam logic [2:0] TBL_WX = 3'd0;
    localparam logic [2:0] TBL_WH = 3'd1;
    localparam logic [2:0] TBL_WY = 3'd2;
    localparam logic [2:0] TBL_BH = 3'd3;
    localparam logic [2:0] TBL_BY = 3'd4;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [2:0]         weight_table;
        logic [5:0]         weight_row;
        logic [5:0]         weight_col;
        logic signed [15:0] weight_value;
        logic signed [15:0] sample;
    } in_t;

    typedef struct packed {
        logic signed [15:0] prediction;
        logic               saturated;
    } out_t;

    typedef enum logic [2:0] {
        OP_WX,
        OP_WH,
        OP_WY,
        OP_BH,
        OP_BY,
        OP_SAMPLE
    } op_e;

    typedef struct packed {
        op_e                op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [15:0] data;
    } qent_t;

    typedef enum logic [2:0] {
        TERM_INPUT,
        TERM_REC,
        TERM_BIAS,
        TERM_OUT_BIAS,
        TERM_OUT_W
    } term_e;

    typedef struct packed {
        logic  valid;
        term_e kind;
        logic  first;
        logic  last;
        logic  is_out;
    } tag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_HID,
        ST_DRAIN_HID,
        ST_WAIT_OUT,
        ST_RUN_OUT,
        ST_DRAIN_OUT
    } st_e;

endpackage

>>> rtl/ernn_front.sv
// ----------------------------------------------------------------------------
// ernn_front
// Accepts input words, classifies them into queue operations and drops
// weight writes that fall outside the stores.
// ----------------------------------------------------------------------------
module ernn_front import ernn_pkg::*; #(
    parameter int HIDDEN = 64
) (
    input  logic  s_valid,
    output logic  s_ready,
    input  in_t   s_data,
    output logic  push,
    input  logic  push_ready,
    output qent_t push_data
);

    logic row_ok;
    logic col_ok;
    logic keep;

    assign row_ok  = int'(s_data.weight_row) < HIDDEN;
    assign col_ok  = int'(s_data.weight_col) < HIDDEN;
    assign s_ready = push_ready;

    // classify the word
    always_comb begin
        push_data.op   = OP_SAMPLE;
        push_data.row  = s_data.weight_row;
        push_data.col  = s_data.weight_col;
        push_data.data = s_data.weight_value;
        keep           = 1'b0;
        if (s_data.command == CMD_SAMPLE) begin
            push_data.data = s_data.sample;
            keep           = 1'b1;
        end else begin
            unique case (s_data.weight_table)
                TBL_WX: begin
                    push_data.op = OP_WX;
                    keep         = row_ok;
                end
                TBL_WH: begin
                    push_data.op = OP_WH;
                    keep         = row_ok && col_ok;
                end
                TBL_WY: begin
                    push_data.op = OP_WY;
                    keep         = row_ok;
                end
                TBL_BH: begin
                    push_data.op = OP_BH;
                    keep         = row_ok;
                end
                TBL_BY: begin
                    push_data.op = OP_BY;
                    keep         = 1'b1;
                end
                default: begin
                    keep = 1'b0;
                end
            endcase
        end
    end

    // drop out-of-range writes and unknown table codes, enqueue the rest
    assign push = s_valid && push_ready && keep;

endmodule

>>> rtl/ernn_queue.sv
// ----------------------------------------------------------------------------
// ernn_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ernn_queue import ernn_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    output logic  push_ready,
    input  qent_t push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output qent_t pop_data
);

    qent_t      ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_data   = ent_reg[rd_ptr_reg];
    assign pop        = pop_valid && pop_ready;

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/ernn_back.sv
// ----------------------------------------------------------------------------
// ernn_back
// Weight stores, ping-pong hidden banks and one shared multiply-accumulate
// pipeline that runs the hidden update and the output projection.
// ----------------------------------------------------------------------------
module ernn_back import ernn_pkg::*; #(
    parameter int HIDDEN    = 64,
    parameter int MAX_SEQ   = 64,
    parameter int DATA_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [SEQ_LEN_W-1:0] seq_len,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  qent_t                q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data
);

    localparam int HW     = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int RW     = (HIDDEN > 1) ? $clog2(HIDDEN * HIDDEN) : 1;
    localparam int KW     = $clog2(HIDDEN + 2);
    localparam int OW     = (DATA_BITS > 16) ? DATA_BITS : 16;
    localparam int PW     = 16 + OW;
    localparam int ACC_W  = PW + $clog2(HIDDEN + 2);
    localparam int CNT_W  = $clog2(MAX_SEQ + 1);
    localparam int CMP_W  = (CNT_W > SEQ_LEN_W) ? CNT_W : SEQ_LEN_W;
    localparam longint DMAX = (longint'(1) << (DATA_BITS - 1)) - 1;
    localparam longint DMIN = -DMAX - 1;
    localparam longint HI2  = (DMAX < 32767) ? DMAX : 32767;
    localparam longint LO2  = (DMIN > -32768) ? DMIN : -32768;
    localparam longint RND  = longint'(1) << (FRAC_BITS - 1);
    localparam longint ONE  = longint'(1) << FRAC_BITS;

    // memories
    logic signed [15:0]        wx_mem  [HIDDEN];
    logic signed [15:0]        bh_mem  [HIDDEN];
    logic signed [15:0]        wy_mem  [HIDDEN];
    logic signed [15:0]        wh_mem  [HIDDEN * HIDDEN];
    logic [DATA_BITS-1:0]      hid0_mem [HIDDEN];
    logic [DATA_BITS-1:0]      hid1_mem [HIDDEN];
    logic signed [15:0]        wx_rd_reg;
    logic signed [15:0]        bh_rd_reg;
    logic signed [15:0]        wy_rd_reg;
    logic signed [15:0]        wh_rd_reg;
    logic [DATA_BITS-1:0]      hid0_rd_reg;
    logic [DATA_BITS-1:0]      hid1_rd_reg;
    logic signed [15:0]        by_reg;

    // control
    st_e               state_reg;
    st_e               state_next;
    logic [KW-1:0]     k_reg;
    logic [HW-1:0]     row_reg;
    logic signed [15:0] x_reg;
    logic              cur_bank_reg;
    logic              hzero_reg;
    logic              clip_reg;
    logic [CNT_W-1:0]  step_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;

    // pipeline
    tag_t              tag_issue;
    tag_t              tag_b_reg;
    tag_t              tag_c_reg;
    tag_t              tag_d_reg;
    logic [HW-1:0]     row_b_reg;
    logic [HW-1:0]     row_c_reg;
    logic [HW-1:0]     row_d_reg;
    logic signed [15:0]   w_b;
    logic signed [OW-1:0] op_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic              pipe_empty;
    logic              seq_end;
    logic [CMP_W-1:0]  len;
    logic [HW-1:0]     rd_j;
    logic [RW-1:0]     wh_rd_addr;
    logic [HW-1:0]     wr_row;
    logic [RW-1:0]     wh_wr_addr;
    logic              wr_en;
    logic              k_last_hid;
    logic              k_last_out;
    logic              row_last;

    logic signed [ACC_W:0] rsum;
    logic signed [ACC_W:0] qv;
    logic              fin;
    logic              fin_hid;
    logic              fin_out;
    logic              hclip;
    logic [DATA_BITS-1:0] hval;
    logic signed [15:0] yval;
    logic              oclip;

    assign pipe_empty = !tag_b_reg.valid && !tag_c_reg.valid && !tag_d_reg.valid;
    assign k_last_hid = k_reg == KW'(HIDDEN + 1);
    assign k_last_out = k_reg == KW'(HIDDEN);
    assign row_last   = row_reg == HW'(HIDDEN - 1);
    assign rd_j       = HW'(k_reg - 1'b1);
    assign wh_rd_addr = RW'(int'(row_reg) * HIDDEN + int'(rd_j));
    assign wr_row     = HW'(q_data.row);
    assign wh_wr_addr = RW'(int'(q_data.row) * HIDDEN + int'(q_data.col));
    assign wr_en      = q_valid && q_ready && (q_data.op != OP_SAMPLE);

    // effective sequence length
    always_comb begin
        if (seq_len == '0) begin
            len = CMP_W'(1);
        end else if (int'(seq_len) > MAX_SEQ) begin
            len = CMP_W'(MAX_SEQ);
        end else begin
            len = CMP_W'(seq_len);
        end
    end
    assign seq_end = (CMP_W'(step_reg) + CMP_W'(1)) >= len;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && q_data.op == OP_SAMPLE) begin
                    state_next = ST_RUN_HID;
                end
            end
            ST_RUN_HID: begin
                if (k_last_hid && row_last) begin
                    state_next = ST_DRAIN_HID;
                end
            end
            ST_DRAIN_HID: begin
                if (pipe_empty) begin
                    state_next = seq_end ? ST_WAIT_OUT : ST_IDLE;
                end
            end
            ST_WAIT_OUT: begin
                if (!m_valid_reg) begin
                    state_next = ST_RUN_OUT;
                end
            end
            ST_RUN_OUT: begin
                if (k_last_out) begin
                    state_next = ST_DRAIN_OUT;
                end
            end
            ST_DRAIN_OUT: begin
                if (pipe_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: pop and term issue
    always_comb begin
        q_ready          = 1'b0;
        tag_issue.valid  = 1'b0;
        tag_issue.kind   = TERM_REC;
        tag_issue.first  = 1'b0;
        tag_issue.last   = 1'b0;
        tag_issue.is_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
            end
            ST_RUN_HID: begin
                tag_issue.valid = 1'b1;
                tag_issue.first = k_reg == '0;
                tag_issue.last  = k_last_hid;
                if (k_reg == '0) begin
                    tag_issue.kind = TERM_INPUT;
                end else if (k_last_hid) begin
                    tag_issue.kind = TERM_BIAS;
                end else begin
                    tag_issue.kind = TERM_REC;
                end
            end
            ST_RUN_OUT: begin
                tag_issue.valid  = 1'b1;
                tag_issue.is_out = 1'b1;
                tag_issue.first  = k_reg == '0;
                tag_issue.last   = k_last_out;
                tag_issue.kind   = (k_reg == '0) ? TERM_OUT_BIAS : TERM_OUT_W;
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    // state, counters and sequence bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            row_reg      <= '0;
            cur_bank_reg <= 1'b0;
            hzero_reg    <= 1'b1;
            clip_reg     <= 1'b0;
            step_reg     <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    k_reg   <= '0;
                    row_reg <= '0;
                end
                ST_RUN_HID: begin
                    if (k_last_hid) begin
                        k_reg   <= '0;
                        row_reg <= row_reg + 1'b1;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN_HID: begin
                    if (pipe_empty) begin
                        cur_bank_reg <= !cur_bank_reg;
                        hzero_reg    <= 1'b0;
                        step_reg     <= step_reg + 1'b1;
                    end
                end
                ST_WAIT_OUT: begin
                    k_reg <= '0;
                end
                ST_RUN_OUT: begin
                    k_reg <= k_reg + 1'b1;
                end
                ST_DRAIN_OUT: begin
                    if (pipe_empty) begin
                        hzero_reg <= 1'b1;
                        clip_reg  <= 1'b0;
                        step_reg  <= '0;
                    end
                end
                default: begin
                    k_reg <= '0;
                end
            endcase
            if (fin_hid && hclip) begin
                clip_reg <= 1'b1;
            end
        end
    end

    // latch the sample
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready && q_data.op == OP_SAMPLE) begin
            x_reg <= q_data.data;
        end
    end

    // weight stores: write from the queue, read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en && q_data.op == OP_WX) begin
            wx_mem[wr_row] <= q_data.data;
        end
        wx_rd_reg <= wx_mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && q_data.op == OP_BH) begin
            bh_mem[wr_row] <= q_data.data;
        end
        bh_rd_reg <= bh_mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && q_data.op == OP_WY) begin
            wy_mem[wr_row] <= q_data.data;
        end
        wy_rd_reg <= wy_mem[rd_j];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && q_data.op == OP_WH) begin
            wh_mem[wh_wr_addr] <= q_data.data;
        end
        wh_rd_reg <= wh_mem[wh_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && q_data.op == OP_BY) begin
            by_reg <= q_data.data;
        end
    end

    // hidden banks: read the current one, write the other
    always_ff @(posedge aclk) begin
        if (fin_hid && cur_bank_reg) begin
            hid0_mem[row_d_reg] <= hval;
        end
        hid0_rd_reg <= hid0_mem[rd_j];
    end

    always_ff @(posedge aclk) begin
        if (fin_hid && !cur_bank_reg) begin
            hid1_mem[row_d_reg] <= hval;
        end
        hid1_rd_reg <= hid1_mem[rd_j];
    end

    // stage B: pick operands
    always_comb begin
        logic [DATA_BITS-1:0] h_rd;
        h_rd = cur_bank_reg ? hid1_rd_reg : hid0_rd_reg;
        case (tag_b_reg.kind)
            TERM_INPUT: begin
                w_b  = wx_rd_reg;
                op_b = OW'(x_reg);
            end
            TERM_BIAS: begin
                w_b  = bh_rd_reg;
                op_b = OW'(ONE);
            end
            TERM_OUT_BIAS: begin
                w_b  = by_reg;
                op_b = OW'(ONE);
            end
            TERM_OUT_W: begin
                w_b  = wy_rd_reg;
                op_b = hzero_reg ? '0 : $signed(OW'(h_rd));
            end
            default: begin
                w_b  = wh_rd_reg;
                op_b = hzero_reg ? '0 : $signed(OW'(h_rd));
            end
        endcase
    end

    // advance pipeline tags; only the valid bits are reset
    always_ff @(posedge aclk) begin
        tag_b_reg.kind   <= tag_issue.kind;
        tag_b_reg.first  <= tag_issue.first;
        tag_b_reg.last   <= tag_issue.last;
        tag_b_reg.is_out <= tag_issue.is_out;
        row_b_reg        <= row_reg;
        tag_c_reg.kind   <= tag_b_reg.kind;
        tag_c_reg.first  <= tag_b_reg.first;
        tag_c_reg.last   <= tag_b_reg.last;
        tag_c_reg.is_out <= tag_b_reg.is_out;
        row_c_reg        <= row_b_reg;
        tag_d_reg.kind   <= tag_c_reg.kind;
        tag_d_reg.first  <= tag_c_reg.first;
        tag_d_reg.last   <= tag_c_reg.last;
        tag_d_reg.is_out <= tag_c_reg.is_out;
        row_d_reg        <= row_c_reg;
        if (!aresetn) begin
            tag_b_reg.valid <= 1'b0;
            tag_c_reg.valid <= 1'b0;
            tag_d_reg.valid <= 1'b0;
        end else begin
            tag_b_reg.valid <= tag_issue.valid;
            tag_c_reg.valid <= tag_b_reg.valid;
            tag_d_reg.valid <= tag_c_reg.valid && tag_c_reg.last;
        end
    end

    // stage C: multiply
    always_ff @(posedge aclk) begin
        prod_reg <= w_b * op_b;
    end

    // stage D: accumulate
    always_ff @(posedge aclk) begin
        if (tag_c_reg.valid) begin
            if (tag_c_reg.first) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // stage E: round, saturate, rectify
    assign fin     = tag_d_reg.valid && tag_d_reg.last;
    assign fin_hid = fin && !tag_d_reg.is_out;
    assign fin_out = fin && tag_d_reg.is_out;
    assign rsum    = {acc_reg[ACC_W-1], acc_reg} + $signed((ACC_W + 1)'(RND));
    assign qv      = rsum >>> FRAC_BITS;

    always_comb begin
        hclip = 1'b0;
        hval  = '0;
        if (qv > $signed((ACC_W + 1)'(DMAX))) begin
            hclip = 1'b1;
            hval  = DATA_BITS'(DMAX);
        end else if (qv < $signed((ACC_W + 1)'(DMIN))) begin
            hclip = 1'b1;
        end else if (qv > 0) begin
            hval = DATA_BITS'(qv);
        end
    end

    always_comb begin
        oclip = 1'b0;
        yval  = 16'(qv);
        if (qv > $signed((ACC_W + 1)'(HI2))) begin
            oclip = 1'b1;
            yval  = 16'(HI2);
        end else if (qv < $signed((ACC_W + 1)'(LO2))) begin
            oclip = 1'b1;
            yval  = 16'(LO2);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_out) begin
            m_data_reg.prediction <= yval;
            m_data_reg.saturated  <= clip_reg || oclip;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fin_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_out |-> !m_valid_reg)
        else $error("result finished while output word still pending");
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> pipe_empty)
        else $error("pipeline busy while idle");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(step_reg) <= MAX_SEQ)
        else $error("step count past maximum sequence length");
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> pipe_empty)
        else $error("weight write while pipeline active");
`endif

endmodule

>>> rtl/elman_rnn_relu_inference_core.sv
// Flow: a sample is popped from the queue in idle, the hidden terms are issued row by
//   row and the pipeline drains; at a sequence end the core waits for a free output
//   word, issues the output terms and drains again before the word is presented.
// The back end takes no new queue entry, sample or weight write, until it is idle
//   again: the single shared multiply-accumulate runs one sample at a time.
// Reset: synchronous active-low aresetn; hidden state reads as zero, seq_len is 10.
// ----------------------------------------------------------------------------
// elman_rnn_relu_inference_core
// Elman recurrent cell with ReLU: front classifier, two-entry queue and a
// back end that owns the weight stores and the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module elman_rnn_relu_inference_core import ernn_pkg::*; #(
    parameter int HIDDEN    = 64,
    parameter int MAX_SEQ   = 64,
    parameter int DATA_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SEQ_LEN_W-1:0] cfg_data
);

    logic                 push;
    logic                 push_ready;
    qent_t                push_data;
    logic                 q_valid;
    logic                 q_ready;
    qent_t                q_data;
    logic [SEQ_LEN_W-1:0] seq_len_reg;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg <= SEQ_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            seq_len_reg <= cfg_data;
        end
    end

    ernn_front #(.HIDDEN(HIDDEN)) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ernn_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    ernn_back #(
        .HIDDEN    (HIDDEN),
        .MAX_SEQ   (MAX_SEQ),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seq_len (seq_len_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
